@@ design/shadow_diff_dirty_run_detector_top_macros.svh @@
// assertion macros shared by the dirty run detector modules
`ifndef SHADOW_DIFF_DIRTY_RUN_DETECTOR_TOP_MACROS_SVH
`define SHADOW_DIFF_DIRTY_RUN_DETECTOR_TOP_MACROS_SVH

// same-cycle implication, sampled on clk and quiet while rst_n is low
`define SDRD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk and quiet while rst_n is low
`define SDRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/sdrd_pkg.sv @@
// shared constants and types of the dirty run detector
package sdrd_pkg;

    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] STRIDE_RESET = 7'd16;
    localparam int BYTE_W = 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // classification of one request as it passes from front to back
    typedef struct packed {
        logic elem_close;
        logic elem_dirty;
        logic pay_last;
    } entry_flags_t;

    // fill level of the classification queue as seen by the front
    typedef struct packed {
        logic full;
        logic almost_full;
    } q_status_t;

endpackage

@@ design/sdrd_in_if.sv @@
// byte request channel
interface sdrd_in_if;

    logic                         valid;
    logic                         ready;
    logic [sdrd_pkg::BYTE_W-1:0]  byte_value;
    logic                         is_last;

    modport source (output valid, output byte_value, output is_last, input ready);
    modport sink (input valid, input byte_value, input is_last, output ready);

endinterface

@@ design/sdrd_out_if.sv @@
// dirty run result channel
interface sdrd_out_if #(
    parameter int CAPACITY_BYTES = 4096
);

    localparam int ELEM_W = $clog2(CAPACITY_BYTES);

    logic              valid;
    logic              ready;
    logic [ELEM_W-1:0] run_first;
    logic [ELEM_W:0]   run_count;
    logic              at_end;

    modport source (output valid, output run_first, output run_count, output at_end,
                    input ready);
    modport sink (input valid, input run_first, input run_count, input at_end,
                  output ready);

endinterface

@@ design/shadow_diff_dirty_run_detector_top.sv @@
// top level of the shadow compare dirty run detector
// throughput: one byte per cycle when the queue has room and no clearing pass runs,
// limited by one shadow ram read and write per byte; a result leaves through the
// compare stage register, the queue and the result register. reset: rst_n clears
// all position and run state and loads stride 16; after reset a clearing pass
// zeroes the shadow, during which no byte is taken while stride writes are accepted
module shadow_diff_dirty_run_detector_top #(
    parameter int CAPACITY_BYTES   = 4096,
    parameter int MAX_STRIDE_BYTES = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [sdrd_pkg::CFG_W-1:0] cfg_wdata,
    sdrd_in_if.sink                    byte_stream,
    sdrd_out_if.source                 run_stream
);

    localparam int ELEM_W = $clog2(CAPACITY_BYTES);

    logic [sdrd_pkg::CFG_W-1:0] stride_reg, stride_next;

    sdrd_pkg::q_status_t    q_status;
    logic                   push;
    sdrd_pkg::entry_flags_t push_flags;
    logic [ELEM_W:0]        push_elem;
    logic                   pop;
    logic                   q_valid;
    sdrd_pkg::entry_flags_t q_flags;
    logic [ELEM_W:0]        q_elem;

    // stride register
    assign stride_next = cfg_we ? cfg_wdata : stride_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg <= sdrd_pkg::STRIDE_RESET;
        end
        else
        begin
            stride_reg <= stride_next;
        end
    end

    sdrd_front #(
        .CAPACITY_BYTES   (CAPACITY_BYTES),
        .MAX_STRIDE_BYTES (MAX_STRIDE_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .stride      (stride_reg),
        .q_status    (q_status),
        .push        (push),
        .push_flags  (push_flags),
        .push_elem   (push_elem)
    );

    sdrd_queue #(
        .ELEM_W (ELEM_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_flags (push_flags),
        .push_elem  (push_elem),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_flags    (q_flags),
        .q_elem     (q_elem),
        .q_status   (q_status)
    );

    sdrd_back #(
        .CAPACITY_BYTES (CAPACITY_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_flags    (q_flags),
        .q_elem     (q_elem),
        .pop        (pop),
        .run_stream (run_stream)
    );

endmodule

@@ design/sdrd_ram.sv @@
// generic single write, single read ram with registered read data
module sdrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns the old contents when the same address is written
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/sdrd_queue.sv @@
// short fifo of classified requests between front and back
`include "shadow_diff_dirty_run_detector_top_macros.svh"

module sdrd_queue #(
    parameter int ELEM_W = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  sdrd_pkg::entry_flags_t push_flags,
    input  logic [ELEM_W:0]        push_elem,
    input  logic                   pop,
    output logic                   q_valid,
    output sdrd_pkg::entry_flags_t q_flags,
    output logic [ELEM_W:0]        q_elem,
    output sdrd_pkg::q_status_t    q_status
);

    sdrd_pkg::entry_flags_t flags_mem [sdrd_pkg::QUEUE_DEPTH];
    logic [ELEM_W:0]        elem_mem  [sdrd_pkg::QUEUE_DEPTH];

    logic [sdrd_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [sdrd_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [sdrd_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;

    // storage write
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            flags_mem[wr_ptr_reg] <= push_flags;
            elem_mem[wr_ptr_reg]  <= push_elem;
        end
    end

    // pointer and fill level
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // head of queue and status
    assign q_valid  = (count_reg != '0);
    assign q_flags  = flags_mem[rd_ptr_reg];
    assign q_elem   = elem_mem[rd_ptr_reg];
    assign q_status.full =
        (count_reg == sdrd_pkg::QUEUE_CNT_W'(sdrd_pkg::QUEUE_DEPTH));
    assign q_status.almost_full =
        (count_reg >= sdrd_pkg::QUEUE_CNT_W'(sdrd_pkg::QUEUE_DEPTH - 1));

    `SDRD_ASSERT_NOW(a_no_overflow, push && !pop, !q_status.full, "queue overflow")
    `SDRD_ASSERT_NOW(a_no_underflow, pop, count_reg != '0, "queue underflow")

endmodule

@@ design/sdrd_front.sv @@
// front: byte acceptance, shadow compare and element classification
`include "shadow_diff_dirty_run_detector_top_macros.svh"

module sdrd_front #(
    parameter int CAPACITY_BYTES   = 4096,
    parameter int MAX_STRIDE_BYTES = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    sdrd_in_if.sink                                byte_stream,
    input  logic [sdrd_pkg::CFG_W-1:0]             stride,
    input  sdrd_pkg::q_status_t                    q_status,
    output logic                                   push,
    output sdrd_pkg::entry_flags_t                 push_flags,
    output logic [$clog2(CAPACITY_BYTES):0]        push_elem
);

    localparam int ADDR_W = $clog2(CAPACITY_BYTES);
    localparam int POS_W  = $clog2(CAPACITY_BYTES + 1);
    localparam int ELEM_W = ADDR_W;
    localparam int MAX_W  = $clog2(MAX_STRIDE_BYTES + 1);
    localparam int SW     = (MAX_W > sdrd_pkg::CFG_W) ? MAX_W : sdrd_pkg::CFG_W;

    // clearing pass state
    logic              clear_busy_reg, clear_busy_next;
    logic [ADDR_W-1:0] clear_addr_reg, clear_addr_next;

    // payload position state
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [SW-1:0]     offset_reg, offset_next;
    logic [ELEM_W:0]   elem_reg, elem_next;

    // compare stage
    logic                         s1_valid_reg;
    logic [sdrd_pkg::BYTE_W-1:0]  s1_byte_reg;
    logic                         s1_incap_reg;
    logic                         s1_close_reg;
    logic                         s1_last_reg;
    logic [ELEM_W:0]              s1_elem_reg;
    logic                         acc_dirty_reg, acc_dirty_next;

    logic [SW-1:0]                stride_ext;
    logic [SW-1:0]                eff_stride;
    logic [SW:0]                  off_inc;
    logic                         in_cap;
    logic                         elem_close;
    logic                         accept;
    logic                         ram_we;
    logic [ADDR_W-1:0]            ram_waddr;
    logic [sdrd_pkg::BYTE_W-1:0]  ram_wdata;
    logic [sdrd_pkg::BYTE_W-1:0]  shadow_byte;
    logic                         byte_diff;
    logic                         elem_dirty;

    // room for the request in flight and the one taken now
    assign byte_stream.ready = !clear_busy_reg && !q_status.full &&
                               !(q_status.almost_full && s1_valid_reg);
    assign accept = byte_stream.valid && byte_stream.ready;

    // stride clamped to one through the maximum
    always_comb
    begin
        stride_ext = SW'(stride);
        if (stride_ext == '0)
        begin
            eff_stride = SW'(1);
        end
        else if (stride_ext > SW'(MAX_STRIDE_BYTES))
        begin
            eff_stride = SW'(MAX_STRIDE_BYTES);
        end
        else
        begin
            eff_stride = stride_ext;
        end
    end

    // element boundary detection
    always_comb
    begin
        in_cap  = (pos_reg < POS_W'(CAPACITY_BYTES));
        off_inc = {1'b0, offset_reg} + (SW + 1)'(1);
        if (in_cap)
        begin
            elem_close = (off_inc >= {1'b0, eff_stride}) || byte_stream.is_last;
        end
        else
        begin
            elem_close = byte_stream.is_last && (offset_reg != '0);
        end
    end

    // position, offset and element counters
    always_comb
    begin
        pos_next    = pos_reg;
        offset_next = offset_reg;
        elem_next   = elem_reg;
        if (accept)
        begin
            if (byte_stream.is_last)
            begin
                pos_next    = '0;
                offset_next = '0;
                elem_next   = '0;
            end
            else
            begin
                if (in_cap)
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
                if (elem_close)
                begin
                    offset_next = '0;
                    elem_next   = elem_reg + (ELEM_W + 1)'(1);
                end
                else if (in_cap)
                begin
                    offset_next = off_inc[SW-1:0];
                end
            end
        end
    end

    // clearing pass walks the shadow once after reset
    always_comb
    begin
        clear_busy_next = clear_busy_reg;
        clear_addr_next = clear_addr_reg;
        if (clear_busy_reg)
        begin
            clear_addr_next = clear_addr_reg + 1'b1;
            if (clear_addr_reg == ADDR_W'(CAPACITY_BYTES - 1))
            begin
                clear_busy_next = 1'b0;
            end
        end
    end

    // shadow write port: clearing pass or new byte
    always_comb
    begin
        ram_we    = clear_busy_reg || (accept && in_cap);
        ram_waddr = clear_busy_reg ? clear_addr_reg : pos_reg[ADDR_W-1:0];
        ram_wdata = clear_busy_reg ? '0 : byte_stream.byte_value;
    end

    sdrd_ram #(
        .WIDTH (sdrd_pkg::BYTE_W),
        .DEPTH (CAPACITY_BYTES)
    ) u_shadow (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (accept && in_cap),
        .raddr   (pos_reg[ADDR_W-1:0]),
        .rd_data (shadow_byte)
    );

    // compare with old shadow byte and accumulate element dirtiness
    always_comb
    begin
        byte_diff      = s1_incap_reg && (shadow_byte != s1_byte_reg);
        elem_dirty     = acc_dirty_reg || byte_diff;
        push           = s1_valid_reg && (s1_close_reg || s1_last_reg);
        acc_dirty_next = acc_dirty_reg;
        if (s1_valid_reg)
        begin
            acc_dirty_next = (s1_close_reg || s1_last_reg) ? 1'b0 : elem_dirty;
        end
    end

    assign push_flags.elem_close = s1_close_reg;
    assign push_flags.elem_dirty = elem_dirty;
    assign push_flags.pay_last   = s1_last_reg;
    assign push_elem             = s1_elem_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
            pos_reg        <= '0;
            offset_reg     <= '0;
            elem_reg       <= '0;
            s1_valid_reg   <= 1'b0;
            acc_dirty_reg  <= 1'b0;
        end
        else
        begin
            clear_busy_reg <= clear_busy_next;
            clear_addr_reg <= clear_addr_next;
            pos_reg        <= pos_next;
            offset_reg     <= offset_next;
            elem_reg       <= elem_next;
            s1_valid_reg   <= accept;
            acc_dirty_reg  <= acc_dirty_next;
        end
    end

    // compare stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg  <= byte_stream.byte_value;
            s1_incap_reg <= in_cap;
            s1_close_reg <= elem_close;
            s1_last_reg  <= byte_stream.is_last;
            s1_elem_reg  <= elem_reg;
        end
    end

    `SDRD_ASSERT_NOW(a_no_accept_clearing, accept, !clear_busy_reg, "request during clear")
    `SDRD_ASSERT_NEXT(a_last_rewinds, accept && byte_stream.is_last,
        pos_reg == '0 && elem_reg == '0 && offset_reg == '0, "payload end not rewound")

endmodule

@@ design/sdrd_back.sv @@
// back: run coalescing and result register
`include "shadow_diff_dirty_run_detector_top_macros.svh"

module sdrd_back #(
    parameter int CAPACITY_BYTES = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  sdrd_pkg::entry_flags_t          q_flags,
    input  logic [$clog2(CAPACITY_BYTES):0] q_elem,
    output logic                            pop,
    sdrd_out_if.source                      run_stream
);

    localparam int ELEM_W = $clog2(CAPACITY_BYTES);

    logic              open_reg, open_next;
    logic [ELEM_W-1:0] start_reg, start_next;

    logic              out_valid_reg, out_valid_next;
    logic [ELEM_W-1:0] out_first_reg;
    logic [ELEM_W:0]   out_count_reg;
    logic              out_end_reg;

    logic              take;
    logic              open_mid;
    logic [ELEM_W-1:0] start_mid;
    logic              emit_clean;
    logic              emit_end;
    logic [ELEM_W:0]   end_elem;
    logic [ELEM_W:0]   run_len;

    assign take = q_valid && (!out_valid_reg || run_stream.ready);
    assign pop  = take;

    // run open/close decision for one classified request
    always_comb
    begin
        emit_clean = q_flags.elem_close && !q_flags.elem_dirty && open_reg;
        open_mid   = open_reg;
        start_mid  = start_reg;
        if (q_flags.elem_close && q_flags.elem_dirty)
        begin
            open_mid = 1'b1;
            if (!open_reg)
            begin
                start_mid = q_elem[ELEM_W-1:0];
            end
        end
        else if (emit_clean)
        begin
            open_mid = 1'b0;
        end
        end_elem = q_flags.elem_close ? q_elem + (ELEM_W + 1)'(1) : q_elem;
        emit_end = q_flags.pay_last && !emit_clean && open_mid;
        run_len  = emit_clean ? q_elem - {1'b0, start_mid} : end_elem - {1'b0, start_mid};
    end

    // run state, cleared at payload end
    always_comb
    begin
        open_next  = open_reg;
        start_next = start_reg;
        if (take)
        begin
            open_next  = q_flags.pay_last ? 1'b0 : open_mid;
            start_next = q_flags.pay_last ? '0 : start_mid;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = emit_clean || emit_end;
        end
        else if (run_stream.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg      <= 1'b0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            open_reg      <= open_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && (emit_clean || emit_end))
        begin
            out_first_reg <= start_mid;
            out_count_reg <= run_len;
            out_end_reg   <= emit_end;
        end
    end

    assign run_stream.valid     = out_valid_reg;
    assign run_stream.run_first = out_first_reg;
    assign run_stream.run_count = out_count_reg;
    assign run_stream.at_end    = out_end_reg;

    `SDRD_ASSERT_NOW(a_run_nonempty, run_stream.valid, run_stream.run_count != '0,
        "empty run reported")

endmodule

@@ tb/sv/tb.sv @@
// self-checking bench for the shadow compare dirty run detector: byte requests in, dirty runs out
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP_BYTES     = 4096;
    localparam int MAX_STRIDE    = 64;
    localparam int ELEM_W        = 12;
    localparam int QUIET_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_MAX    = 10;

    typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_style_t;

    typedef struct {
        logic [sdrd_pkg::BYTE_W-1:0] value;
        logic                        last;
    } byte_req_t;

    typedef struct packed {
        logic [ELEM_W-1:0] first;
        logic [ELEM_W:0]   count;
        logic              at_end;
    } run_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_we;
    logic [sdrd_pkg::CFG_W-1:0] cfg_wdata;

    sdrd_in_if                               byte_if ();
    sdrd_out_if #(.CAPACITY_BYTES(CAP_BYTES)) run_if ();

    shadow_diff_dirty_run_detector_top #(
        .CAPACITY_BYTES   (CAP_BYTES),
        .MAX_STRIDE_BYTES (MAX_STRIDE)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .byte_stream (byte_if),
        .run_stream  (run_if)
    );

    // stimulus side
    byte_req_t   pending_reqs[$];
    logic [7:0]  plan_shadow[CAP_BYTES];
    logic [6:0]  plan_stride = sdrd_pkg::STRIDE_RESET;
    idle_style_t send_style = IDLE_NONE;
    idle_style_t recv_style = IDLE_NONE;
    int          send_gap = 0;
    int          recv_stall = 0;
    byte_req_t   next_req;
    logic        byte_taken = 1'b0;
    logic        run_taken = 1'b0;

    // predicted detector state
    logic [7:0]  shadow_copy[CAP_BYTES];
    logic [6:0]  stride_reg = sdrd_pkg::STRIDE_RESET;
    int          fill_pos = 0;
    int          elem_fill = 0;
    int          elem_index = 0;
    logic        elem_changed = 1'b0;
    logic        run_active = 1'b0;
    int          run_origin = 0;
    run_t        expected_runs[$];
    run_t        want;

    // bookkeeping
    int bytes_queued = 0;
    int bytes_taken = 0;
    int payloads_queued = 0;
    int runs_seen = 0;
    int strides_tried = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    always #1 clk = ~clk;

    function automatic int eff_stride(input logic [6:0] s);
        if (s == 0)
            return 1;
        if (s > MAX_STRIDE)
            return MAX_STRIDE;
        return s;
    endfunction

    function automatic int draw_idle(input idle_style_t style);
        case (style)
            IDLE_FULL:   return $urandom_range(0, 17);
            IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 17) : 0;
            default:     return 0;
        endcase
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("mismatch: %s", msg);
    endtask

    // run closes: record what the detector should emit
    task automatic report_run(input int end_elem, input logic at_end);
        run_t r;
        r.first  = run_origin[ELEM_W-1:0];
        r.count  = (ELEM_W + 1)'(end_elem - run_origin);
        r.at_end = at_end;
        expected_runs.push_back(r);
        run_active = 1'b0;
    endtask

    // element completes: open a run if dirty, close the open run if clean
    task automatic close_element(output bit reported);
        reported = 1'b0;
        if (elem_changed)
        begin
            if (!run_active)
            begin
                run_active = 1'b1;
                run_origin = elem_index;
            end
        end
        else if (run_active)
        begin
            report_run(elem_index, 1'b0);
            reported = 1'b1;
        end
        elem_index++;
        elem_fill = 0;
        elem_changed = 1'b0;
    endtask

    // one accepted byte request through the shadow compare
    task automatic track_byte(input logic [7:0] value, input logic last);
        int eff;
        bit reported;
        eff = eff_stride(stride_reg);
        reported = 1'b0;
        if (fill_pos < CAP_BYTES)
        begin
            if (shadow_copy[fill_pos] != value)
                elem_changed = 1'b1;
            shadow_copy[fill_pos] = value;
            fill_pos++;
            elem_fill++;
            if (elem_fill >= eff || last)
                close_element(reported);
        end
        else if (last && elem_fill > 0)
        begin
            close_element(reported);
        end
        if (last)
        begin
            if (!reported && run_active)
                report_run(elem_index, 1'b1);
            fill_pos = 0;
            elem_fill = 0;
            elem_index = 0;
            elem_changed = 1'b0;
            run_active = 1'b0;
            run_origin = 0;
        end
    endtask

    task automatic add_req(input logic [7:0] value, input logic last);
        byte_req_t r;
        r.value = value;
        r.last = last;
        pending_reqs.push_back(r);
        bytes_queued++;
        if (last)
            payloads_queued++;
    endtask

    // payload built element by element against the planned shadow contents
    task automatic queue_payload(input int len, input int dirty_pct);
        int eff;
        int k;
        bit dirty;
        logic [7:0] v;
        eff = eff_stride(plan_stride);
        dirty = 1'b0;
        k = 0;
        for (int p = 0; p < len; p++)
        begin
            if (p < CAP_BYTES)
            begin
                if (p % eff == 0)
                begin
                    dirty = ($urandom_range(0, 99) < dirty_pct);
                    k = p + $urandom_range(0, eff - 1);
                end
                if (!dirty)
                    v = plan_shadow[p];
                else if (p == k)
                    v = plan_shadow[p] ^ 8'($urandom_range(1, 255));
                else if ($urandom_range(0, 1) == 1)
                    v = 8'($urandom);
                else
                    v = plan_shadow[p];
                plan_shadow[p] = v;
            end
            else
            begin
                v = 8'($urandom);
            end
            add_req(v, p == len - 1);
        end
    endtask

    task automatic set_stride(input logic [6:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        plan_stride = value;
        strides_tried++;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // wait for every request taken and every run returned, then let the pipe settle
    task automatic wait_idle();
        while (bytes_taken != bytes_queued || expected_runs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        @(posedge clk);
    endtask

    // request driver: hold each byte until taken, then idle for the drawn gap
    always @(negedge clk)
    begin
        if (rst_n && (!byte_if.valid || byte_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                byte_if.valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                next_req = pending_reqs.pop_front();
                byte_if.valid <= 1'b1;
                byte_if.byte_value <= next_req.value;
                byte_if.is_last <= next_req.last;
                send_gap = draw_idle(send_style);
            end
            else
            begin
                byte_if.valid <= 1'b0;
            end
        end
    end

    // result receiver: after each taken run, stall a drawn number of cycles
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (run_taken)
                recv_stall = draw_idle(recv_style);
            if (recv_stall > 0)
            begin
                recv_stall--;
                run_if.ready <= 1'b0;
            end
            else
            begin
                run_if.ready <= 1'b1;
            end
        end
    end

    // monitor: stride writes, run checks, byte prediction and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                stride_reg = cfg_wdata;
            byte_taken <= byte_if.valid && byte_if.ready;
            run_taken <= run_if.valid && run_if.ready;

            if (run_if.valid && run_if.ready)
            begin
                runs_seen++;
                if (expected_runs.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected run first=%0d count=%0d at_end=%0b",
                                            run_if.run_first, run_if.run_count, run_if.at_end));
                end
                else
                begin
                    want = expected_runs.pop_front();
                    if (run_if.run_first !== want.first)
                        note_mismatch($sformatf("run_first expected %0d got %0d",
                                                want.first, run_if.run_first));
                    if (run_if.run_count !== want.count)
                        note_mismatch($sformatf("run_count expected %0d got %0d",
                                                want.count, run_if.run_count));
                    if (run_if.at_end !== want.at_end)
                        note_mismatch($sformatf("at_end expected %0b got %0b",
                                                want.at_end, run_if.at_end));
                end
            end

            if (byte_if.valid && byte_if.ready)
            begin
                track_byte(byte_if.byte_value, byte_if.is_last);
                bytes_taken++;
            end

            if ((byte_if.valid && byte_if.ready) || (run_if.valid && run_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no request moved for %0d cycles", QUIET_LIMIT);
                $display("shadow_diff_dirty_run_detector_top regression: fail");
                $finish;
            end
        end
    end

    // test sequence
    initial
    begin
        logic [6:0] stride_plan[12];
        int target;
        int phase_bytes;
        int len;
        int eff;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        byte_if.valid = 1'b0;
        byte_if.byte_value = '0;
        byte_if.is_last = 1'b0;
        run_if.ready = 1'b0;
        foreach (plan_shadow[i])
        begin
            plan_shadow[i] = 8'h00;
            shadow_copy[i] = 8'h00;
        end
        stride_plan = '{7'd0, 7'd127, 7'd64, 7'd65, 7'd1, 7'd42, 7'd85, 7'd3, 7'd16, 7'd7,
                        7'd0, 7'd0};
        stride_plan[10] = 7'($urandom_range(1, 64));
        stride_plan[11] = 7'($urandom);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: stride written during the clearing pass
        send_style = IDLE_FULL;
        recv_style = IDLE_FULL;
        set_stride(7'd2);
        // clean single byte, then a dirty single byte closed by payload end
        add_req(8'h00, 1'b1);
        add_req(8'hFF, 1'b1);
        // dirty middle element closed by a clean last element
        add_req(8'hFF, 1'b0);
        add_req(8'h00, 1'b0);
        add_req(8'h12, 1'b0);
        add_req(8'h00, 1'b0);
        add_req(8'h00, 1'b0);
        add_req(8'h00, 1'b1);
        // trailing partial element counts as complete
        add_req(8'h34, 1'b0);
        add_req(8'h00, 1'b0);
        add_req(8'h99, 1'b1);
        // walking bits
        add_req(8'h55, 1'b0);
        add_req(8'hAA, 1'b0);
        add_req(8'h01, 1'b0);
        add_req(8'h02, 1'b0);
        add_req(8'h04, 1'b0);
        add_req(8'h08, 1'b0);
        add_req(8'h10, 1'b0);
        add_req(8'h20, 1'b0);
        add_req(8'h40, 1'b0);
        add_req(8'h80, 1'b1);
        wait_idle();

        // random phases over stride settings
        foreach (stride_plan[ph])
        begin
            send_style = idle_style_t'($urandom_range(0, 2));
            recv_style = idle_style_t'($urandom_range(0, 2));
            set_stride(stride_plan[ph]);
            eff = eff_stride(stride_plan[ph]);
            target = $urandom_range(60, 100);
            phase_bytes = 0;
            while (phase_bytes < target)
            begin
                case ($urandom_range(0, 9))
                    0:       len = 1;
                    7, 8:    len = $urandom_range(1, 64);
                    9:       len = $urandom_range(100, 300);
                    default: len = $urandom_range(1, eff * 4);
                endcase
                queue_payload(len, $urandom_range(0, 100));
                phase_bytes += len;
            end
            wait_idle();
        end

        if (expected_runs.size() != 0)
            note_mismatch($sformatf("%0d runs never arrived", expected_runs.size()));

        $display("covered %0d bytes in %0d payloads over %0d stride settings, %0d runs checked",
                 bytes_taken, payloads_queued, strides_tried, runs_seen);
        $display("included clamped strides, partial last elements and %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("shadow_diff_dirty_run_detector_top regression: pass");
        else
            $display("shadow_diff_dirty_run_detector_top regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/sdrd_pkg.sv
design/sdrd_in_if.sv
design/sdrd_out_if.sv
design/sdrd_ram.sv
design/sdrd_queue.sv
design/sdrd_front.sv
design/sdrd_back.sv
design/shadow_diff_dirty_run_detector_top.sv
tb/sv/tb.sv
